[hw/rtl/lhi_pkg.sv]
// Shared types, constants, saturating arithmetic and microprogram for the Lorenz Heun integrator.
package lhi_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SIGMA_W   = 31;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 31;
  localparam int unsigned PROG_LEN  = 25;
  localparam int unsigned PC_W      = $clog2(PROG_LEN);

  localparam logic [PC_W-1:0] PROG_LAST = PC_W'(PROG_LEN - 1);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] POS_RESET = DATA_W'(1) <<< FRAC_BITS;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(655360);
  localparam logic [SIGMA_W-1:0] RHO_RESET   = SIGMA_W'(1835008);
  localparam logic [SIGMA_W-1:0] BETA_RESET  = SIGMA_W'(174763);
  localparam logic [DT_W-1:0]    DT_RESET    = DT_W'(655);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MWB,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  // Operand and destination selects; OPD_ZERO as a destination writes nothing
  typedef enum logic [4:0] {
    OPD_ZERO,
    OPD_X, OPD_Y, OPD_Z,
    OPD_M0, OPD_M1, OPD_M2,
    OPD_F0, OPD_F1, OPD_F2,
    OPD_G0, OPD_G1, OPD_G2,
    OPD_T0, OPD_T1,
    OPD_SIGMA, OPD_RHO, OPD_BETA, OPD_DT
  } opnd_e;

  // ADD/SUB: dst = a +/- b. MUL: dst = c + ((a * b) >> (FRAC_BITS + half))
  typedef struct packed {
    op_e   op;
    opnd_e src_a;
    opnd_e src_b;
    opnd_e src_c;
    opnd_e dst;
    logic  half;
  } instr_t;

  typedef struct packed {
    logic   issue;
    logic   wb;
    logic   load;
    logic   capture;
    instr_t instr;
  } dp_cmd_t;

  function automatic instr_t mk(input op_e op, input opnd_e a, input opnd_e b,
                                input opnd_e c, input opnd_e d, input logic half);
    instr_t r;
    r.op    = op;
    r.src_a = a;
    r.src_b = b;
    r.src_c = c;
    r.dst   = d;
    r.half  = half;
    return r;
  endfunction

  // One Heun step: slope at the state, trial point, slope there, averaged update
  function automatic instr_t prog_fetch(input logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      5'd0:  r = mk(OP_SUB, OPD_Y,     OPD_X,  OPD_ZERO, OPD_T0, 1'b0);
      5'd1:  r = mk(OP_MUL, OPD_SIGMA, OPD_T0, OPD_ZERO, OPD_F0, 1'b0);
      5'd2:  r = mk(OP_SUB, OPD_RHO,   OPD_Z,  OPD_ZERO, OPD_T0, 1'b0);
      5'd3:  r = mk(OP_MUL, OPD_X,     OPD_T0, OPD_ZERO, OPD_T1, 1'b0);
      5'd4:  r = mk(OP_SUB, OPD_T1,    OPD_Y,  OPD_ZERO, OPD_F1, 1'b0);
      5'd5:  r = mk(OP_MUL, OPD_X,     OPD_Y,  OPD_ZERO, OPD_T1, 1'b0);
      5'd6:  r = mk(OP_MUL, OPD_BETA,  OPD_Z,  OPD_ZERO, OPD_T0, 1'b0);
      5'd7:  r = mk(OP_SUB, OPD_T1,    OPD_T0, OPD_ZERO, OPD_F2, 1'b0);
      5'd8:  r = mk(OP_MUL, OPD_DT,    OPD_F0, OPD_X,    OPD_M0, 1'b0);
      5'd9:  r = mk(OP_MUL, OPD_DT,    OPD_F1, OPD_Y,    OPD_M1, 1'b0);
      5'd10: r = mk(OP_MUL, OPD_DT,    OPD_F2, OPD_Z,    OPD_M2, 1'b0);
      5'd11: r = mk(OP_SUB, OPD_M1,    OPD_M0, OPD_ZERO, OPD_T0, 1'b0);
      5'd12: r = mk(OP_MUL, OPD_SIGMA, OPD_T0, OPD_ZERO, OPD_G0, 1'b0);
      5'd13: r = mk(OP_SUB, OPD_RHO,   OPD_M2, OPD_ZERO, OPD_T0, 1'b0);
      5'd14: r = mk(OP_MUL, OPD_M0,    OPD_T0, OPD_ZERO, OPD_T1, 1'b0);
      5'd15: r = mk(OP_SUB, OPD_T1,    OPD_M1, OPD_ZERO, OPD_G1, 1'b0);
      5'd16: r = mk(OP_MUL, OPD_M0,    OPD_M1, OPD_ZERO, OPD_T1, 1'b0);
      5'd17: r = mk(OP_MUL, OPD_BETA,  OPD_M2, OPD_ZERO, OPD_T0, 1'b0);
      5'd18: r = mk(OP_SUB, OPD_T1,    OPD_T0, OPD_ZERO, OPD_G2, 1'b0);
      5'd19: r = mk(OP_ADD, OPD_F0,    OPD_G0, OPD_ZERO, OPD_F0, 1'b0);
      5'd20: r = mk(OP_ADD, OPD_F1,    OPD_G1, OPD_ZERO, OPD_F1, 1'b0);
      5'd21: r = mk(OP_ADD, OPD_F2,    OPD_G2, OPD_ZERO, OPD_F2, 1'b0);
      5'd22: r = mk(OP_MUL, OPD_DT,    OPD_F0, OPD_X,    OPD_X,  1'b1);
      5'd23: r = mk(OP_MUL, OPD_DT,    OPD_F1, OPD_Y,    OPD_Y,  1'b1);
      5'd24: r = mk(OP_MUL, OPD_DT,    OPD_F2, OPD_Z,    OPD_Z,  1'b1);
      default: r = mk(OP_ADD, OPD_ZERO, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0);
    endcase
    return r;
  endfunction

  // Saturating add or subtract
  function automatic logic signed [DATA_W-1:0] sat_addsub(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b,
                                                          input logic sub);
    logic signed [DATA_W:0] s;
    if (sub) begin
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    end else begin
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    end
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // Floor-shift a full product back to fixed point and saturate
  function automatic logic signed [DATA_W-1:0] sat_scale(input logic signed [PROD_W-1:0] p,
                                                         input logic half);
    logic signed [PROD_W-1:0] q;
    q = half ? (p >>> (FRAC_BITS + 1)) : (p >>> FRAC_BITS);
    if ((&q[PROD_W-1:DATA_W-1]) || !(|q[PROD_W-1:DATA_W-1])) begin
      return q[DATA_W-1:0];
    end
    return q[PROD_W-1] ? DATA_MIN : DATA_MAX;
  endfunction

endpackage

[hw/rtl/lhi_datapath.sv]
// Datapath: state and scratch registers, shared multiplier, saturating adder, config and result registers.
module lhi_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lhi_pkg::dp_cmd_t                   cmd_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_x_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_y_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_z_i,
  input  logic                               cfg_we_i,
  input  logic [lhi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lhi_pkg::CFG_DAT_W-1:0]      cfg_wdata_i,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_x_o,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_y_o,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_z_o
);
  import lhi_pkg::*;

  logic signed [DATA_W-1:0] x_q, y_q, z_q;
  logic signed [DATA_W-1:0] m0_q, m1_q, m2_q;
  logic signed [DATA_W-1:0] f0_q, f1_q, f2_q;
  logic signed [DATA_W-1:0] g0_q, g1_q, g2_q;
  logic signed [DATA_W-1:0] t0_q, t1_q;
  logic [SIGMA_W-1:0]       sigma_q, rho_q, beta_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] out_x_q, out_y_q, out_z_q;

  logic signed [DATA_W-1:0] opa, opb, opc;
  logic signed [DATA_W-1:0] alu_res, mul_res, wr_data;
  logic                     wr_en;

  function automatic logic signed [DATA_W-1:0] pick(input opnd_e sel);
    logic signed [DATA_W-1:0] v;
    case (sel)
      OPD_X:     v = x_q;
      OPD_Y:     v = y_q;
      OPD_Z:     v = z_q;
      OPD_M0:    v = m0_q;
      OPD_M1:    v = m1_q;
      OPD_M2:    v = m2_q;
      OPD_F0:    v = f0_q;
      OPD_F1:    v = f1_q;
      OPD_F2:    v = f2_q;
      OPD_G0:    v = g0_q;
      OPD_G1:    v = g1_q;
      OPD_G2:    v = g2_q;
      OPD_T0:    v = t0_q;
      OPD_T1:    v = t1_q;
      OPD_SIGMA: v = {1'b0, sigma_q};
      OPD_RHO:   v = {1'b0, rho_q};
      OPD_BETA:  v = {1'b0, beta_q};
      OPD_DT:    v = {{(DATA_W-DT_W){1'b0}}, dt_q};
      default:   v = '0;
    endcase
    return v;
  endfunction

  // Select operands and form the add/sub and multiply-accumulate results
  always_comb begin
    opa     = pick(cmd_i.instr.src_a);
    opb     = pick(cmd_i.instr.src_b);
    opc     = pick(cmd_i.instr.src_c);
    alu_res = sat_addsub(opa, opb, cmd_i.instr.op == OP_SUB);
    mul_res = sat_addsub(opc, sat_scale(prod_q, cmd_i.instr.half), 1'b0);
    wr_en   = (cmd_i.issue && cmd_i.instr.op != OP_MUL) || cmd_i.wb;
    wr_data = cmd_i.wb ? mul_res : alu_res;
  end

  // Register the full product
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && cmd_i.instr.op == OP_MUL) begin
      prod_q <= opa * opb;
    end
  end

  // Write back to the scratch registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (cmd_i.instr.dst)
        OPD_M0:  m0_q <= wr_data;
        OPD_M1:  m1_q <= wr_data;
        OPD_M2:  m2_q <= wr_data;
        OPD_F0:  f0_q <= wr_data;
        OPD_F1:  f1_q <= wr_data;
        OPD_F2:  f2_q <= wr_data;
        OPD_G0:  g0_q <= wr_data;
        OPD_G1:  g1_q <= wr_data;
        OPD_G2:  g2_q <= wr_data;
        OPD_T0:  t0_q <= wr_data;
        OPD_T1:  t1_q <= wr_data;
        default: ;
      endcase
    end
  end

  // Hold the integrator state; load beats replace it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= POS_RESET;
      y_q <= POS_RESET;
      z_q <= POS_RESET;
    end else if (cmd_i.load) begin
      x_q <= load_x_i;
      y_q <= load_y_i;
      z_q <= load_z_i;
    end else if (wr_en) begin
      case (cmd_i.instr.dst)
        OPD_X:   x_q <= wr_data;
        OPD_Y:   y_q <= wr_data;
        OPD_Z:   z_q <= wr_data;
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RESET;
      rho_q   <= RHO_RESET;
      beta_q  <= BETA_RESET;
      dt_q    <= DT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIGMA: sigma_q <= cfg_wdata_i;
        CFG_RHO:   rho_q   <= cfg_wdata_i;
        CFG_BETA:  beta_q  <= cfg_wdata_i;
        CFG_DT:    dt_q    <= cfg_wdata_i[DT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Capture the finished state into the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_x_q <= x_q;
      out_y_q <= y_q;
      out_z_q <= z_q;
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

[hw/rtl/lhi_ctrl.sv]
// Controller: input/output handshakes and the microprogram sequencer.
module lhi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lhi_pkg::dp_cmd_t cmd_o
);
  import lhi_pkg::*;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  instr_t          instr;

  assign instr = prog_fetch(pc_q);

  // Next state, sequencing and datapath commands
  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    out_valid_d   = out_valid_q;
    in_ready_o    = 1'b0;
    cmd_o.issue   = 1'b0;
    cmd_o.wb      = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.instr   = instr;

    // drop the result once the beat is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DONE;
          end else begin
            pc_d    = '0;
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        cmd_o.issue = 1'b1;
        if (instr.op == OP_MUL) begin
          state_d = ST_MWB;
        end else if (pc_q == PROG_LAST) begin
          state_d = ST_DONE;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_MWB: begin
        cmd_o.wb = 1'b1;
        if (pc_q == PROG_LAST) begin
          state_d = ST_DONE;
        end else begin
          pc_d    = pc_q + 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted beat keeps the input closed until its result is captured
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while previous item still in progress");

  // The result register is never overwritten while a beat is waiting
  a_capture_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // Multiply writeback follows the issue of a multiply
  a_wb_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MWB) |-> ($past(state_q) == ST_EXEC && $past(instr.op) == OP_MUL
                             && $stable(pc_q)))
    else $error("multiply writeback without a multiply issue");

  // The sequencer stays inside the microprogram
  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC || state_q == ST_MWB) |-> (pc_q <= PROG_LAST))
    else $error("microprogram counter out of range");

endmodule

[hw/rtl/lorenz_heun_integrator_core.sv]
// Top level of the Lorenz Heun integrator: controller and datapath.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o  kind_i, load_x_i, load_y_i, load_z_i
//  out      output     out_valid_o / out_ready_i out_x_o, out_y_o, out_z_o
//  cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A step beat runs a 25-instruction microprogram on one shared 32x32 multiplier:
// 11 add/sub instructions write back as they issue, and 14 multiplies issue and then
// write back from the registered product; a load beat goes straight to the result.
// The input reopens once the result is in the output register; a stalled output
// holds the next finished item in the state registers until the output register frees.
// Reset restores the state to (1.0, 1.0, 1.0) and the coefficients to their defaults.
module lorenz_heun_integrator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_x_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_y_i,
  input  logic signed [lhi_pkg::DATA_W-1:0]  load_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_x_o,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_y_o,
  output logic signed [lhi_pkg::DATA_W-1:0]  out_z_o,
  input  logic                               cfg_we_i,
  input  logic [lhi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lhi_pkg::CFG_DAT_W-1:0]      cfg_wdata_i
);
  import lhi_pkg::*;

  dp_cmd_t cmd;

  lhi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lhi_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .load_x_i    (load_x_i),
    .load_y_i    (load_y_i),
    .load_z_i    (load_z_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

endmodule
